@@ src/ipv6c_pkg.sv @@
// Shared types and constants for the IPv6 address text compressor.
`timescale 1ns / 1ps

package ipv6c_pkg;

  localparam int NUM_GROUPS   = 8;
  localparam int GROUP_W      = 16;
  localparam int NIBS_PER_GRP = 4;
  localparam int ADDR_W       = NUM_GROUPS * GROUP_W;
  localparam int HALF_W       = ADDR_W / 2;
  localparam int GIDX_W       = $clog2(NUM_GROUPS);
  localparam int GCNT_W       = $clog2(NUM_GROUPS + 1);
  localparam int NIDX_W       = $clog2(NIBS_PER_GRP);
  localparam int CHAR_W       = 7;
  localparam int RUN_W        = 4;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [RUN_W-1:0]  MIN_RUN_RESET = RUN_W'(1);
  localparam logic [CHAR_W-1:0] ASCII_COLON   = 7'h3a;

  // Classified address handed from front to back.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [GIDX_W-1:0] best_start;
    logic [GCNT_W-1:0] best_len;    // 0: nothing compressed
  } item_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) c = 7'h30 + CHAR_W'(nib);
    else             c = 7'h57 + CHAR_W'(nib);
    return c;
  endfunction

endpackage

@@ src/ipv6c_front.sv @@
// Front stage: takes an address and finds the zero run to compress.
`timescale 1ns / 1ps

module ipv6c_front
  import ipv6c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RUN_W-1:0]  min_zero_run,
  input  logic              in_push,
  input  logic [HALF_W-1:0] in_addr_high,
  input  logic [HALF_W-1:0] in_addr_low,
  output logic              in_full,
  output logic              item_valid,
  output item_t             item,
  input  logic              q_full
);

  logic [ADDR_W-1:0]   addr;
  logic [NUM_GROUPS:0] zero_ext;   // top bit is a non-zero sentinel past group 7
  logic [GCNT_W-1:0]   run;
  logic [GCNT_W-1:0]   best_len;
  logic [GIDX_W-1:0]   best_start;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept, move;

  assign addr = {in_addr_high, in_addr_low};

  always_comb begin
    zero_ext[NUM_GROUPS] = 1'b0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      zero_ext[i] = (addr[ADDR_W-1-i*GROUP_W -: GROUP_W] == '0);
    end
  end

  // Scan groups left to right; strict > keeps the first of equal runs.
  always_comb begin
    run        = '0;
    best_len   = '0;
    best_start = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (zero_ext[i]) run = run + GCNT_W'(1);
      else             run = '0;
      if (zero_ext[i] && !zero_ext[i+1] && (run > best_len) &&
          (RUN_W'(run) >= min_zero_run)) begin
        best_len   = run;
        best_start = GIDX_W'(i + 1 - int'(run));
      end
    end
  end

  assign move      = valid_r && !q_full;
  assign in_full   = valid_r && q_full;
  assign accept    = in_push && !in_full;
  assign valid_nxt = accept ? 1'b1 : (move ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.addr       <= addr;
      item_r.best_start <= best_start;
      item_r.best_len   <= best_len;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ src/ipv6c_queue.sv @@
// Short queue of classified addresses between front and back.
`timescale 1ns / 1ps

module ipv6c_queue
  import ipv6c_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr_r] <= push_item;
  end

endmodule

@@ src/ipv6c_back.sv @@
// Back stage: walks one classified address and emits its text a character per cycle while out_pop takes each one.
`timescale 1ns / 1ps

module ipv6c_back
  import ipv6c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  item_t             q_head,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CHAR_W-1:0] out_text_char,
  output logic              out_last_char
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROUP,
    S_COLON,
    S_DC1,
    S_DC2
  } state_t;

  function automatic logic [GROUP_W-1:0] grp_of(input logic [ADDR_W-1:0] a,
                                                input logic [GIDX_W-1:0] g);
    logic [GROUP_W-1:0] v;
    v = a[(NUM_GROUPS - 1 - int'(g)) * GROUP_W +: GROUP_W];
    return v;
  endfunction

  // Highest non-zero nibble, or 0 for an all-zero group.
  function automatic logic [NIDX_W-1:0] first_nib(input logic [GROUP_W-1:0] v);
    logic [NIDX_W-1:0] k;
    k = '0;
    for (int i = 1; i < NIBS_PER_GRP; i++) begin
      if (v[i*4 +: 4] != 4'd0) k = NIDX_W'(i);
    end
    return k;
  endfunction

  state_t            state_r, state_nxt;
  logic [GIDX_W-1:0] g_r, g_nxt;
  logic [NIDX_W-1:0] k_r, k_nxt;
  item_t             cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;

  logic              advance, finish, compress;
  logic [GROUP_W-1:0] cur_grp;
  logic [GCNT_W-1:0] g_inc, run_end;
  logic [3:0]        cur_nib;

  assign compress = (cur_r.best_len != '0);
  assign cur_grp  = grp_of(cur_r.addr, g_r);
  assign cur_nib  = cur_grp[int'(k_r)*4 +: 4];
  assign g_inc    = GCNT_W'(g_r) + GCNT_W'(1);
  assign run_end  = GCNT_W'(cur_r.best_start) + cur_r.best_len;
  assign advance  = (state_r != S_IDLE) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    finish    = 1'b0;
    q_pop     = 1'b0;

    if (advance) begin
      last_nxt = 1'b0;
      unique case (state_r)
        S_GROUP: begin
          char_nxt = hex_char(cur_nib);
          if (k_r != '0) begin
            k_nxt = k_r - NIDX_W'(1);
          end else if (compress && (g_inc == GCNT_W'(cur_r.best_start))) begin
            state_nxt = S_DC1;
          end else if (g_inc == GCNT_W'(NUM_GROUPS)) begin
            last_nxt = 1'b1;
            finish   = 1'b1;
          end else begin
            state_nxt = S_COLON;
            g_nxt     = GIDX_W'(g_inc);
          end
        end
        S_COLON: begin
          char_nxt  = ASCII_COLON;
          state_nxt = S_GROUP;
          k_nxt     = first_nib(cur_grp);
        end
        S_DC1: begin
          char_nxt  = ASCII_COLON;
          state_nxt = S_DC2;
        end
        S_DC2: begin
          char_nxt = ASCII_COLON;
          if (run_end == GCNT_W'(NUM_GROUPS)) begin
            last_nxt = 1'b1;
            finish   = 1'b1;
          end else begin
            state_nxt = S_GROUP;
            g_nxt     = GIDX_W'(run_end);
            k_nxt     = first_nib(grp_of(cur_r.addr, GIDX_W'(run_end)));
          end
        end
        default: ;
      endcase
    end

    // Load the next address when idle or right behind the last character.
    if ((state_r == S_IDLE) || finish) begin
      if (!q_empty) begin
        q_pop   = 1'b1;
        cur_nxt = q_head;
        g_nxt   = '0;
        k_nxt   = first_nib(grp_of(q_head.addr, '0));
        if ((q_head.best_len != '0) && (q_head.best_start == '0)) state_nxt = S_DC1;
        else                                                      state_nxt = S_GROUP;
      end else begin
        state_nxt = S_IDLE;
      end
    end

    out_valid_nxt = advance ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    g_r    <= g_nxt;
    k_r    <= k_nxt;
    cur_r  <= cur_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_empty     = !out_valid_r;
  assign out_text_char = char_r;
  assign out_last_char = last_r;

endmodule

@@ src/ipv6_address_text_compressor_core.sv @@
// Top level of the IPv6 address text compressor.
`timescale 1ns / 1ps
//
// Turns a 128-bit IPv6 address into its compressed text form, one ASCII
// character per output transaction, last_char set on the final one.
// Input queue side: drive in_addr_high/in_addr_low with in_push while in_full
// is low. Output queue side: out_text_char/out_last_char are valid while
// out_empty is low; assert out_pop to take a character.
// cfg channel: cfg_data is min_zero_run, written when cfg_valid is high
// (cfg_ready is always high). Write it only while the block is idle.
// The first character passes the front register, the queue, the back-end
// address register and the back output register. Throughput: one character
// per cycle while out_pop takes each one; an address gives 2 to 39 characters,
// set by the back-end character sequencer. The front classifies each address
// combinationally into its register and addresses are buffered in a short
// queue, so a queued address starts right behind the previous last character.
// Reset (rst_n low, synchronous): all queues empty, min_zero_run back to 1.
// When out_pop stays low the current character holds, the sequencer stops,
// and the queue then the front fill up until in_full rises.

module ipv6_address_text_compressor_core
  import ipv6c_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [HALF_W-1:0] in_addr_high,
  input  logic [HALF_W-1:0] in_addr_low,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CHAR_W-1:0] out_text_char,
  output logic              out_last_char,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RUN_W-1:0]  cfg_data
);

  logic [RUN_W-1:0] min_zero_run_r;

  logic  front_valid;
  item_t front_item;
  logic  q_full, q_empty, q_pop;
  item_t q_head;

  // Config register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_zero_run_r <= MIN_RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_zero_run_r <= cfg_data;
    end
  end

  ipv6c_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .min_zero_run (min_zero_run_r),
    .in_push      (in_push),
    .in_addr_high (in_addr_high),
    .in_addr_low  (in_addr_low),
    .in_full      (in_full),
    .item_valid   (front_valid),
    .item         (front_item),
    .q_full       (q_full)
  );

  ipv6c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ipv6c_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule
